FILE: rtl/projected_cost_min_path_dp_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the projected cost minimum path block
// Concurrent assertion wrappers that compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PROJECTED_COST_MIN_PATH_DP_TOP_DEFINES_SVH
`define PROJECTED_COST_MIN_PATH_DP_TOP_DEFINES_SVH

`ifndef SYNTH
`define PCMP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PCMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PCMP_ASSERT(lbl, clk, rst_n, prop, msg)
`define PCMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/pcmp_pkg.sv
// ----------------------------------------------------------------------------
// pcmp_pkg
// Shared types and codes for the projected cost minimum path block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcmp_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_ACROSS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLEX   = 2'd3;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic start;
        logic scan_rd;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic cell_last;
        logic row0;
        logic scan_end;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/pcmp_ctrl.sv
// ----------------------------------------------------------------------------
// pcmp_ctrl
// Sequencer for sample accumulation, window scan and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "projected_cost_min_path_dp_top_defines.svh"

module pcmp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pcmp_pkg::t_sts  i_sts,
    output pcmp_pkg::t_cmd  o_cmd
);

    pcmp_pkg::t_state r_state;
    pcmp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcmp_pkg::ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.accept  = 1'b0;
        o_cmd.start   = 1'b0;
        o_cmd.scan_rd = 1'b0;
        o_cmd.finish  = 1'b0;
        case (r_state)
            pcmp_pkg::ST_ACC: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                o_cmd.start  = i_in_valid && i_sts.cell_last;
                if (o_cmd.start) begin
                    n_state = i_sts.row0 ? pcmp_pkg::ST_FIN : pcmp_pkg::ST_SCAN;
                end
            end
            pcmp_pkg::ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = pcmp_pkg::ST_DRAIN;
                end
            end
            pcmp_pkg::ST_DRAIN: begin
                n_state = pcmp_pkg::ST_FIN;
            end
            pcmp_pkg::ST_FIN: begin
                o_cmd.finish = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = pcmp_pkg::ST_ACC;
                end
            end
            default: begin
                n_state = pcmp_pkg::ST_ACC;
            end
        endcase
    end

    `PCMP_ASSERT_NEXT(a_row0_skips_scan, i_clk, i_rst_n, (r_state == pcmp_pkg::ST_ACC) && o_cmd.start && i_sts.row0, r_state == pcmp_pkg::ST_FIN, "row 0 cell entered the window scan")
    `PCMP_ASSERT_NEXT(a_fin_returns, i_clk, i_rst_n, (r_state == pcmp_pkg::ST_FIN) && i_sts.out_free, r_state == pcmp_pkg::ST_ACC, "finish did not return to accumulation")

endmodule

FILE: rtl/pcmp_datapath.sv
// ----------------------------------------------------------------------------
// pcmp_datapath
// Counters, row cost memory, window minimum and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "projected_cost_min_path_dp_top_defines.svh"

module pcmp_datapath #(
    parameter int MAX_FRAMES = 256,
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_ACROSS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pcmp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pcmp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [7:0]                        i_cost,
    input  logic                              i_out_ready,
    input  pcmp_pkg::t_cmd                    i_cmd,
    output pcmp_pkg::t_sts                    o_sts,
    output logic                              o_out_valid,
    output logic [9:0]                        o_row_index,
    output logic [7:0]                        o_frame_index,
    output logic [15:0]                       o_cumulative_cost,
    output logic signed [5:0]                 o_path_offset,
    output logic                              o_pass_done,
    output logic [15:0]                       o_best_cost,
    output logic [7:0]                        o_best_frame
);

    localparam int FW  = $clog2(MAX_FRAMES);
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW  = (MAX_ACROSS > 1) ? $clog2(MAX_ACROSS) : 1;
    localparam int NFW = ($clog2(MAX_FRAMES + 1) > 9) ? $clog2(MAX_FRAMES + 1) : 9;
    localparam int NRW = ($clog2(MAX_ROWS + 1) > 11) ? $clog2(MAX_ROWS + 1) : 11;
    localparam int NAW = ($clog2(MAX_ACROSS + 1) > 11) ? $clog2(MAX_ACROSS + 1) : 11;
    localparam int SW  = ((FW > 5) ? FW : 5) + 1;
    localparam int CMW = (SW > NFW) ? SW : NFW;
    localparam int OW  = ((FW + 1) > 6) ? (FW + 1) : 6;

    logic [10:0] r_across;
    logic [10:0] r_rows;
    logic [8:0]  r_frames;
    logic [4:0]  r_flex;

    logic [15:0]   r_cell_sum;
    logic [AW-1:0] r_smp_cnt;
    logic [FW-1:0] r_frame_cnt;
    logic [RW-1:0] r_row_cnt;
    logic [15:0]   r_min_cost;
    logic [FW-1:0] r_min_frame;
    logic          r_bank;

    logic [15:0]   r_base;
    logic [FW-1:0] r_lo;
    logic [FW-1:0] r_hi;
    logic [FW-1:0] r_addr;
    logic          r_rd_v;
    logic [15:0]   r_rd_data;
    logic [FW-1:0] r_rd_idx;
    logic [15:0]   r_best;
    logic [FW-1:0] r_chosen;

    logic [15:0] r_mem [2**(FW+1)];

    logic              r_out_valid;
    logic [9:0]        r_o_row;
    logic [7:0]        r_o_frame;
    logic [15:0]       r_o_cum;
    logic signed [5:0] r_o_off;
    logic              r_o_done;
    logic [15:0]       r_o_best;
    logic [7:0]        r_o_best_frame;

    logic [NAW-1:0] na_ext, na;
    logic [NRW-1:0] nr_ext, nr;
    logic [NFW-1:0] nf_ext, nf;
    logic [15:0]    n_sum;
    logic [CMW-1:0] j_c, fl_c, lo_c, hi_c, nfm1_c;
    logic [15:0]    cum;
    logic [OW-1:0]  off_full;
    logic [5:0]     off;
    logic           last_row, row_end, pass_end, upd_min;
    logic [15:0]    n_min_cost;
    logic [FW-1:0]  n_min_frame;
    logic [NRW-1:0] row_ext;
    logic [NFW-1:0] frame_ext, min_frame_ext;

    always_comb begin
        na_ext = NAW'(r_across);
        if (na_ext == '0) begin
            na = NAW'(1);
        end else if (na_ext > NAW'(MAX_ACROSS)) begin
            na = NAW'(MAX_ACROSS);
        end else begin
            na = na_ext;
        end
        nr_ext = NRW'(r_rows);
        if (nr_ext == '0) begin
            nr = NRW'(1);
        end else if (nr_ext > NRW'(MAX_ROWS)) begin
            nr = NRW'(MAX_ROWS);
        end else begin
            nr = nr_ext;
        end
        nf_ext = NFW'(r_frames);
        if (nf_ext == '0) begin
            nf = NFW'(1);
        end else if (nf_ext > NFW'(MAX_FRAMES)) begin
            nf = NFW'(MAX_FRAMES);
        end else begin
            nf = nf_ext;
        end
    end

    assign n_sum = r_cell_sum + {8'd0, i_cost};

    always_comb begin
        j_c    = CMW'(r_frame_cnt);
        fl_c   = CMW'(r_flex);
        nfm1_c = CMW'(nf - NFW'(1));
        lo_c   = (j_c > fl_c) ? (j_c - fl_c) : '0;
        hi_c   = j_c + fl_c;
        if (hi_c > nfm1_c) begin
            hi_c = nfm1_c;
        end
        if (hi_c < lo_c) begin
            hi_c = lo_c;
        end
    end

    always_comb begin
        cum         = (r_row_cnt == '0) ? r_base : (r_base + r_best);
        off_full    = OW'(r_chosen) - OW'(r_frame_cnt);
        off         = (r_row_cnt == '0) ? 6'd0 : off_full[5:0];
        last_row    = (NRW'(r_row_cnt) + NRW'(1)) >= nr;
        row_end     = (NFW'(r_frame_cnt) + NFW'(1)) >= nf;
        pass_end    = last_row && row_end;
        upd_min     = last_row && ((r_frame_cnt == '0) || (cum < r_min_cost));
        n_min_cost  = upd_min ? cum : r_min_cost;
        n_min_frame = upd_min ? r_frame_cnt : r_min_frame;
        row_ext       = NRW'(r_row_cnt);
        frame_ext     = NFW'(r_frame_cnt);
        min_frame_ext = NFW'(n_min_frame);
    end

    assign o_sts.cell_last = (NAW'(r_smp_cnt) + NAW'(1)) >= na;
    assign o_sts.row0      = (r_row_cnt == '0);
    assign o_sts.scan_end  = (r_addr == r_hi);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_across <= 11'd1;
            r_rows   <= 11'd1;
            r_frames <= 9'd1;
            r_flex   <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcmp_pkg::CFG_ACROSS: r_across <= i_cfg_data;
                pcmp_pkg::CFG_ROWS:   r_rows   <= i_cfg_data;
                pcmp_pkg::CFG_FRAMES: r_frames <= i_cfg_data[8:0];
                pcmp_pkg::CFG_FLEX:   r_flex   <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_sum  <= '0;
            r_smp_cnt   <= '0;
            r_frame_cnt <= '0;
            r_row_cnt   <= '0;
            r_min_cost  <= '1;
            r_min_frame <= '0;
            r_bank      <= 1'b0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.scan_rd;
            if (i_cmd.accept) begin
                if (i_cmd.start) begin
                    r_cell_sum <= '0;
                    r_smp_cnt  <= '0;
                end else begin
                    r_cell_sum <= n_sum;
                    r_smp_cnt  <= r_smp_cnt + AW'(1);
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                if (row_end) begin
                    r_frame_cnt <= '0;
                    r_bank      <= ~r_bank;
                    if (pass_end) begin
                        r_row_cnt   <= '0;
                        r_min_cost  <= '1;
                        r_min_frame <= '0;
                    end else begin
                        r_row_cnt   <= r_row_cnt + RW'(1);
                        r_min_cost  <= n_min_cost;
                        r_min_frame <= n_min_frame;
                    end
                end else begin
                    r_frame_cnt <= r_frame_cnt + FW'(1);
                    r_min_cost  <= n_min_cost;
                    r_min_frame <= n_min_frame;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_base <= n_sum;
            r_lo   <= lo_c[FW-1:0];
            r_hi   <= hi_c[FW-1:0];
            r_addr <= lo_c[FW-1:0];
        end else if (i_cmd.scan_rd) begin
            r_addr <= r_addr + FW'(1);
        end
        if (r_rd_v && ((r_rd_idx == r_lo) || (r_rd_data < r_best))) begin
            r_best   <= r_rd_data;
            r_chosen <= r_rd_idx;
        end
        if (i_cmd.finish) begin
            r_o_row        <= row_ext[9:0];
            r_o_frame      <= frame_ext[7:0];
            r_o_cum        <= cum;
            r_o_off        <= off;
            r_o_done       <= pass_end;
            r_o_best       <= pass_end ? n_min_cost : 16'd0;
            r_o_best_frame <= pass_end ? min_frame_ext[7:0] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_rd_data <= r_mem[{r_bank, r_addr}];
            r_rd_idx  <= r_addr;
        end
        if (i_cmd.finish) begin
            r_mem[{~r_bank, r_frame_cnt}] <= cum;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_row_index       = r_o_row;
    assign o_frame_index     = r_o_frame;
    assign o_cumulative_cost = r_o_cum;
    assign o_path_offset     = r_o_off;
    assign o_pass_done       = r_o_done;
    assign o_best_cost       = r_o_best;
    assign o_best_frame      = r_o_best_frame;

    `PCMP_ASSERT(a_read_in_window, i_clk, i_rst_n, r_rd_v |-> ((r_rd_idx >= r_lo) && (r_rd_idx <= r_hi)), "window read outside its bounds")
    `PCMP_ASSERT(a_frame_in_store, i_clk, i_rst_n, {1'b0, r_frame_cnt} < (FW+1)'(MAX_FRAMES), "frame counter beyond the row store")
    `PCMP_ASSERT(a_no_overwrite, i_clk, i_rst_n, (r_out_valid && !i_out_ready) |-> !i_cmd.finish, "pending result overwritten")

endmodule

FILE: rtl/projected_cost_min_path_dp_top.sv
// ----------------------------------------------------------------------------
// projected_cost_min_path_dp_top
// Minimum cost path dynamic program over a projected cost table.
// ----------------------------------------------------------------------------
// Cost samples enter on the input channel (i_in_valid / o_in_ready), one word
// per sample, ordered by row, then frame, then position across. Each group of
// across_count samples forms one cell. Every finished cell leaves one word on
// the output channel (o_out_valid / i_out_ready) with its cumulative cost and
// path offset; the last cell of the pass also carries the row minimum.
// A sample that does not close a cell is accepted while accumulating.
// A closing sample on row 0 goes straight to the finishing step. On later rows
// the previous row's window is scanned through the single read port of the
// row cost memory, one frame per cycle, then a drain step leads to finishing.
// The result sits in an output register. While it waits, samples of the next
// cell are still accepted; the next cell end holds in its finishing step
// until the register is free.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
// the block is idle. Reset sets the counters, row minimum, configuration and
// valid flags to defaults; row memory and data registers need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module projected_cost_min_path_dp_top #(
    parameter int MAX_FRAMES = 256,
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_ACROSS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pcmp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pcmp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_cost,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [9:0]                        o_row_index,
    output logic [7:0]                        o_frame_index,
    output logic [15:0]                       o_cumulative_cost,
    output logic signed [5:0]                 o_path_offset,
    output logic                              o_pass_done,
    output logic [15:0]                       o_best_cost,
    output logic [7:0]                        o_best_frame
);

    pcmp_pkg::t_cmd cmd;
    pcmp_pkg::t_sts sts;

    pcmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pcmp_datapath #(
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_ROWS   (MAX_ROWS),
        .MAX_ACROSS (MAX_ACROSS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_cost            (i_cost),
        .i_out_ready       (i_out_ready),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_out_valid       (o_out_valid),
        .o_row_index       (o_row_index),
        .o_frame_index     (o_frame_index),
        .o_cumulative_cost (o_cumulative_cost),
        .o_path_offset     (o_path_offset),
        .o_pass_done       (o_pass_done),
        .o_best_cost       (o_best_cost),
        .o_best_frame      (o_best_frame)
    );

endmodule
